[rtl/core/smsvf_pkg.sv]
// Shared types, register map and microcode program of the stereo mid/side filter.
package smsvf_pkg;

    // Configuration register map, in word order.
    typedef enum logic [1:0] {
        REG_GAIN    = 2'd0,
        REG_DAMPING = 2'd1,
        REG_MODE    = 2'd2
    } reg_idx_t;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned MODE_W = 2;

    // Output select codes.
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BAND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd2;

    // Reset coefficients, given with 16 fraction bits.
    localparam longint unsigned GAIN_RESET_Q16 = 22248;
    localparam int unsigned     RESET_FRAC     = 16;

    // Datapath operations of one microcode step.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_DIFF,
        OP_HIGH,
        OP_BAND,
        OP_LOW,
        OP_OUT
    } dp_op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_OUT_BUSY,
        COND_ALWAYS
    } jmp_cond_t;

    localparam int unsigned PC_W = 4;
    localparam logic [PC_W-1:0] PC_LAST = 4'd10;

    // One control word: datapath operation, multiplier operand selects and jump.
    typedef struct packed {
        dp_op_t          op;
        logic            src_diff;   // multiplier takes diff instead of band
        logic            coef_gain;  // multiplier takes gain instead of damping
        logic            hi_half;    // upper half of the operand, accumulate
        jmp_cond_t       cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Control step sent from the sequencer to the datapath.
    typedef struct packed {
        ctrl_word_t word;
        logic       en;
    } dp_ctrl_t;

    // Microcode program: one frame of mid/side filtering.
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, src_diff: 1'b0, coef_gain: 1'b0, hi_half: 1'b0,
              cond: COND_ALWAYS, target: 4'd0};
        unique case (pc)
            4'd0: w = '{OP_LOAD, 1'b0, 1'b0, 1'b0, COND_NO_INPUT, 4'd0};
            4'd1: w = '{OP_MUL,  1'b0, 1'b0, 1'b0, COND_NEVER,    4'd0};
            4'd2: w = '{OP_MUL,  1'b0, 1'b0, 1'b1, COND_NEVER,    4'd0};
            4'd3: w = '{OP_DIFF, 1'b0, 1'b0, 1'b0, COND_NEVER,    4'd0};
            4'd4: w = '{OP_MUL,  1'b1, 1'b1, 1'b0, COND_NEVER,    4'd0};
            4'd5: w = '{OP_MUL,  1'b1, 1'b1, 1'b1, COND_NEVER,    4'd0};
            4'd6: w = '{OP_HIGH, 1'b0, 1'b0, 1'b0, COND_NEVER,    4'd0};
            4'd7: w = '{OP_BAND, 1'b0, 1'b0, 1'b0, COND_NEVER,    4'd0};
            4'd8: w = '{OP_LOW,  1'b0, 1'b0, 1'b0, COND_NEVER,    4'd0};
            4'd9: w = '{OP_OUT,  1'b0, 1'b0, 1'b0, COND_OUT_BUSY, 4'd9};
            default: w = '{OP_NOP, 1'b0, 1'b0, 1'b0, COND_ALWAYS, 4'd0};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/smsvf_datapath.sv]
// Datapath of the mid/side filter: shared multiplier, accumulator and integrators.
module smsvf_datapath #(
    parameter int unsigned SAMPLE_BITS    = 24,
    parameter int unsigned COEF_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smsvf_pkg::dp_ctrl_t           ctrl,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  logic [COEF_FRAC_BITS+2:0]     gain,
    input  logic [COEF_FRAC_BITS+2:0]     damping,
    input  logic [smsvf_pkg::MODE_W-1:0]  mode,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    localparam int unsigned STATE_W = SAMPLE_BITS + COEF_FRAC_BITS;
    localparam int unsigned COEF_W  = COEF_FRAC_BITS + 3;
    localparam int unsigned LO_W    = (STATE_W + 1) / 2;
    localparam int unsigned HI_W    = STATE_W - LO_W;
    localparam int unsigned MA_W    = LO_W + 1;
    localparam int unsigned PR_W    = MA_W + COEF_W + 1;
    localparam int unsigned ACC_W   = STATE_W + COEF_W + 1;
    localparam int unsigned DW      = ACC_W + 2;
    localparam int unsigned OW      = STATE_W + 2;

    logic signed [STATE_W-1:0] mid_reg, side_reg, diff_reg, high_reg;
    logic signed [STATE_W-1:0] band_reg, low_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic [STATE_W-1:0]        mul_src;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [COEF_W:0]    mul_b;
    logic signed [PR_W-1:0]    prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_scaled;
    logic signed [DW-1:0]      diff_sum;
    logic signed [STATE_W:0]   lr_sum, lr_dif;
    logic signed [STATE_W-1:0] sel;
    logic signed [OW-1:0]      sum_l, sum_r;

    // Saturate a wide value to the state width.
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [DW-1:0] v);
        logic ok;
        ok = (&v[DW-1:STATE_W-1]) || !(|v[DW-1:STATE_W-1]);
        if (ok) begin
            sat_state = v[STATE_W-1:0];
        end else begin
            sat_state = {v[DW-1], {(STATE_W-1){~v[DW-1]}}};
        end
    endfunction

    // Round to a sample (half LSB added, then floor) and saturate.
    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] r;
        logic ok;
        r  = (v + OW'(longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        ok = (&r[OW-1:SAMPLE_BITS-1]) || !(|r[OW-1:SAMPLE_BITS-1]);
        if (ok) begin
            to_sample = r[SAMPLE_BITS-1:0];
        end else begin
            to_sample = {r[OW-1], {(SAMPLE_BITS-1){~r[OW-1]}}};
        end
    endfunction

    // Shared multiplier: one half of the state operand times a coefficient.
    always_comb begin
        mul_src = ctrl.word.src_diff ? diff_reg : band_reg;
        if (ctrl.word.hi_half) begin
            mul_a = {{(MA_W-HI_W){mul_src[STATE_W-1]}}, mul_src[STATE_W-1:LO_W]};
        end else begin
            mul_a = {1'b0, mul_src[LO_W-1:0]};
        end
        mul_b    = {1'b0, (ctrl.word.coef_gain ? gain : damping)};
        prod     = mul_a * mul_b;
        prod_ext = {{(ACC_W-PR_W){prod[PR_W-1]}}, prod};
        if (ctrl.word.hi_half) begin
            acc_next = acc_reg + (prod_ext <<< LO_W);
        end else begin
            acc_next = prod_ext;
        end
        acc_scaled = acc_reg >>> COEF_FRAC_BITS;
        diff_sum   = DW'(mid_reg) - DW'(acc_scaled) - DW'(low_reg);
    end

    // Mid and side of the incoming frame, exact with the fraction bits.
    always_comb begin
        lr_sum = STATE_W'(left_in) + STATE_W'(right_in);
        lr_dif = STATE_W'(left_in) - STATE_W'(right_in);
    end

    // Output select and the two sums back to left and right.
    always_comb begin
        if (mode == smsvf_pkg::MODE_BAND) begin
            sel = band_reg;
        end else if (mode == smsvf_pkg::MODE_HIGH) begin
            sel = high_reg;
        end else begin
            sel = low_reg;
        end
        sum_l     = OW'(sel) + OW'(side_reg);
        sum_r     = OW'(sel) - OW'(side_reg);
        left_out  = to_sample(sum_l);
        right_out = to_sample(sum_r);
    end

    // Working registers, written by the step that the control word selects.
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            unique case (ctrl.word.op)
                smsvf_pkg::OP_LOAD: begin
                    mid_reg  <= lr_sum[STATE_W-1:0] <<< (COEF_FRAC_BITS - 1);
                    side_reg <= lr_dif[STATE_W-1:0] <<< (COEF_FRAC_BITS - 1);
                end
                smsvf_pkg::OP_MUL:  acc_reg  <= acc_next;
                smsvf_pkg::OP_DIFF: diff_reg <= sat_state(diff_sum);
                smsvf_pkg::OP_HIGH: high_reg <= sat_state(DW'(acc_scaled));
                default: ;
            endcase
        end
    end

    // Integrator states, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg <= '0;
            low_reg  <= '0;
        end else if (ctrl.en) begin
            if (ctrl.word.op == smsvf_pkg::OP_BAND) begin
                band_reg <= sat_state(DW'(band_reg) + DW'(high_reg));
            end
            if (ctrl.word.op == smsvf_pkg::OP_LOW) begin
                low_reg <= sat_state(DW'(low_reg) + DW'(band_reg));
            end
        end
    end

endmodule

[rtl/core/stereo_mid_svf_filter_unit.sv]
// Top level of the stereo mid/side state variable filter with its sequencer and register port.
// An accepted input beat runs through the microcode steps in order; its result is loaded into the
// output register at the output step. A new frame is taken only at the load step; the microcode
// program of eleven steps runs the shared multiplier twice per coefficient product.
// A result waits in the output register while the sequencer goes on; the sequencer stalls in
// its output step only while an older result is still waiting.
// Synchronous active-low reset sets coefficients to their defaults and clears the integrators.
module stereo_mid_svf_filter_unit #(
    parameter int unsigned SAMPLE_BITS    = 24,
    parameter int unsigned COEF_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smsvf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: left_in, right_in, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // Output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: left_out, right_out, zero padding
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned COEF_W  = COEF_FRAC_BITS + 3;
    localparam int unsigned TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam logic [COEF_W-1:0] GAIN_RESET = COEF_W'(
        (smsvf_pkg::GAIN_RESET_Q16 << COEF_FRAC_BITS) >> smsvf_pkg::RESET_FRAC);
    localparam logic [COEF_W-1:0] DAMP_RESET = COEF_W'(longint'(1) << COEF_FRAC_BITS);

    logic [COEF_W-1:0]            gain_reg, damping_reg;
    logic [smsvf_pkg::MODE_W-1:0] mode_reg;
    logic                         cfg_wr;
    logic [1:0]                   cfg_idx;

    logic [smsvf_pkg::PC_W-1:0]   pc_reg, pc_next;
    smsvf_pkg::ctrl_word_t        uword;
    smsvf_pkg::dp_ctrl_t          dp_ctrl;
    logic                         jump;
    logic                         out_busy;
    logic                         out_load;

    logic signed [SAMPLE_BITS-1:0] left_res, right_res;
    logic [SAMPLE_BITS-1:0]        left_out_reg, right_out_reg;
    logic                          m_tvalid_reg, m_tvalid_next;

    // Register port: write on the access phase, read back any time.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RESET;
            damping_reg <= DAMP_RESET;
            mode_reg    <= smsvf_pkg::MODE_LOW;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                smsvf_pkg::REG_GAIN:    gain_reg    <= pwdata[COEF_W-1:0];
                smsvf_pkg::REG_DAMPING: damping_reg <= pwdata[COEF_W-1:0];
                smsvf_pkg::REG_MODE:    mode_reg    <= pwdata[smsvf_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            smsvf_pkg::REG_GAIN:    prdata = 32'(gain_reg);
            smsvf_pkg::REG_DAMPING: prdata = 32'(damping_reg);
            smsvf_pkg::REG_MODE:    prdata = 32'(mode_reg);
            default:                prdata = '0;
        endcase
    end

    // Sequencer: fetch the control word and decide the jump.
    assign out_busy = m_tvalid_reg && !m_tready;

    always_comb begin
        uword = smsvf_pkg::ucode_rom(pc_reg);
        unique case (uword.cond)
            smsvf_pkg::COND_NEVER:    jump = 1'b0;
            smsvf_pkg::COND_NO_INPUT: jump = !s_tvalid;
            smsvf_pkg::COND_OUT_BUSY: jump = out_busy;
            smsvf_pkg::COND_ALWAYS:   jump = 1'b1;
            default:                  jump = 1'b1;
        endcase
        pc_next = jump ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // A step that waits on a condition does its work only when it moves on.
    always_comb begin
        dp_ctrl.word = uword;
        dp_ctrl.en   = !jump || (uword.cond == smsvf_pkg::COND_ALWAYS);
        s_tready     = (uword.op == smsvf_pkg::OP_LOAD);
        out_load     = (uword.op == smsvf_pkg::OP_OUT) && !out_busy;
    end

    smsvf_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (dp_ctrl),
        .left_in   (s_tdata[SAMPLE_BITS-1:0]),
        .right_in  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .gain      (gain_reg),
        .damping   (damping_reg),
        .mode      (mode_reg),
        .left_out  (left_res),
        .right_out (right_res)
    );

    // Output register: holds the result beat until it is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            left_out_reg  <= left_res;
            right_out_reg <= right_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({right_out_reg, left_out_reg});

    // An accepted beat starts the program at its first computing step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (pc_reg == 4'd1))
        else $error("sequencer did not leave the load step");

    // The step counter stays inside the program.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= smsvf_pkg::PC_LAST)
        else $error("step counter outside the program");

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // No input is taken while a frame is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg != '0) |-> !s_tready)
        else $error("input taken during a frame");

endmodule
